>>> hdl/greedy_rectangle_merge_core_assert.svh
// assertion macros shared by the greedy rectangle merge rtl
// no dependencies; assertions drop out when SYNTHESIS is defined
`ifndef GREEDY_RECTANGLE_MERGE_CORE_ASSERT_SVH
`define GREEDY_RECTANGLE_MERGE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define GRM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("grm assertion failed");
`define GRM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("grm assertion failed during reset");
`else
`define GRM_ASSERT(lbl, clk, rst_n, prop)
`define GRM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> hdl/grm_pkg.sv
// types, constants and box helpers for the greedy rectangle merge core
// no dependencies
package grm_pkg;

  localparam int COORD_BITS  = 12;
  localparam int SIZE_BITS   = COORD_BITS + 1;
  localparam int EDGE_BITS   = COORD_BITS + 3;
  localparam int MARGIN_BITS = 8;

  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 8'd10;
  localparam logic [SIZE_BITS-1:0]   SIZE_MAX     = '1;

  typedef logic signed [EDGE_BITS-1:0] edge_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] in_x;
    logic [COORD_BITS-1:0] in_y;
    logic [SIZE_BITS-1:0]  in_width;
    logic [SIZE_BITS-1:0]  in_height;
    logic                  in_last;
  } rect_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [SIZE_BITS-1:0]  out_width;
    logic [SIZE_BITS-1:0]  out_height;
    logic                  out_last;
    logic                  out_dropped;
  } rect_out_t;

  // stored form, one memory word
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [SIZE_BITS-1:0]  w;
    logic [SIZE_BITS-1:0]  h;
  } rect_t;

  // working form: signed edges, right and bottom exclusive
  typedef struct packed {
    edge_t x0;
    edge_t y0;
    edge_t x1;
    edge_t y1;
  } box_t;

  typedef struct packed {
    logic store;
    logic rd_en;
    logic load_kept;
    logic test;
    logic commit;
    logic flush;
  } grm_cmd_t;

  function automatic box_t rect_to_box(rect_t r);
    box_t b;
    b.x0 = edge_t'(r.x);
    b.y0 = edge_t'(r.y);
    b.x1 = b.x0 + edge_t'(r.w);
    b.y1 = b.y0 + edge_t'(r.h);
    return b;
  endfunction

  function automatic logic box_empty(box_t b);
    return (b.x1 <= b.x0) || (b.y1 <= b.y0);
  endfunction

  // positive-area overlap
  function automatic logic box_overlap(box_t a, box_t b);
    return (a.x0 < b.x1) && (b.x0 < a.x1) && (a.x0 < a.x1) && (b.x0 < b.x1) &&
           (a.y0 < b.y1) && (b.y0 < a.y1) && (a.y0 < a.y1) && (b.y0 < b.y1);
  endfunction

  function automatic box_t box_union(box_t a, box_t b);
    box_t u;
    u.x0 = (a.x0 < b.x0) ? a.x0 : b.x0;
    u.y0 = (a.y0 < b.y0) ? a.y0 : b.y0;
    u.x1 = (a.x1 > b.x1) ? a.x1 : b.x1;
    u.y1 = (a.y1 > b.y1) ? a.y1 : b.y1;
    return u;
  endfunction

  function automatic logic [SIZE_BITS-1:0] sat_size(edge_t v);
    logic [SIZE_BITS-1:0] s;
    if (v < 0) begin
      s = '0;
    end else if (v > edge_t'(SIZE_MAX)) begin
      s = SIZE_MAX;
    end else begin
      s = v[SIZE_BITS-1:0];
    end
    return s;
  endfunction

  function automatic rect_t box_to_rect(box_t b);
    rect_t r;
    r.x = (b.x0 < 0) ? '0 : b.x0[COORD_BITS-1:0];
    r.y = (b.y0 < 0) ? '0 : b.y0[COORD_BITS-1:0];
    r.w = sat_size(b.x1 - b.x0);
    r.h = sat_size(b.y1 - b.y0);
    return r;
  endfunction

endpackage

>>> hdl/grm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module grm_ram #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hdl/grm_datapath.sv
// datapath: rectangle store, absorbed flags, search and kept boxes, result register
// depends on grm_pkg and grm_ram
module grm_datapath import grm_pkg::*; #(
  parameter int MAX_RECTS = 64,
  localparam int AW = $clog2(MAX_RECTS),
  localparam int CW = $clog2(MAX_RECTS + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  grm_cmd_t               cmd_i,
  input  logic [AW-1:0]          rd_addr_i,
  input  logic [AW-1:0]          flag_idx_i,
  input  rect_in_t               item_i,
  input  logic                   cfg_we_i,
  input  logic [MARGIN_BITS-1:0] cfg_data_i,
  output logic [CW-1:0]          count_o,
  output logic                   absorbed_o,
  output logic                   result_valid_o,
  output rect_out_t              result_o
);

  logic [MARGIN_BITS-1:0] margin_q;
  logic [CW-1:0]          count_q;
  logic                   ovf_q;
  logic [MAX_RECTS-1:0]   absorbed_q;
  logic                   pend_v_q;
  logic                   res_v_q;
  box_t                   search_q;
  box_t                   kept_q;
  rect_t                  pend_q;
  rect_out_t              res_q;

  logic                   ram_we;
  rect_t                  wr_rect;
  logic [$bits(rect_t)-1:0] rd_word;
  box_t                   rd_box;
  logic                   hit;
  box_t                   kept_merged;

  assign ram_we  = cmd_i.store && (count_q < CW'(MAX_RECTS));
  assign wr_rect = '{x: item_i.in_x, y: item_i.in_y,
                     w: item_i.in_width, h: item_i.in_height};

  grm_ram #(
    .WIDTH($bits(rect_t)),
    .DEPTH(MAX_RECTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(wr_rect),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_addr_i),
    .rdata_o(rd_word)
  );

  assign rd_box     = rect_to_box(rect_t'(rd_word));
  assign absorbed_o = absorbed_q[flag_idx_i];
  assign hit        = cmd_i.test && !absorbed_o && box_overlap(rd_box, search_q);
  // an empty kept box is replaced by the first rectangle absorbed into it
  assign kept_merged = box_empty(kept_q) ? rd_box : box_union(kept_q, rd_box);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q   <= MARGIN_RESET;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      absorbed_q <= '0;
      pend_v_q   <= 1'b0;
      res_v_q    <= 1'b0;
    end else begin
      res_v_q <= (cmd_i.commit || cmd_i.flush) && pend_v_q;
      if (cfg_we_i) begin
        margin_q <= cfg_data_i;
      end
      if (cmd_i.store) begin
        if (ram_we) begin
          count_q <= count_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (hit) begin
        absorbed_q[flag_idx_i] <= 1'b1;
      end
      if (cmd_i.commit) begin
        pend_v_q <= 1'b1;
      end
      if (cmd_i.flush) begin
        pend_v_q   <= 1'b0;
        count_q    <= '0;
        ovf_q      <= 1'b0;
        absorbed_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_kept) begin
      kept_q   <= rd_box;
      search_q <= '{x0: rd_box.x0 - edge_t'(margin_q), y0: rd_box.y0,
                    x1: rd_box.x1 + edge_t'(margin_q), y1: rd_box.y1};
    end
    if (hit) begin
      search_q <= box_union(search_q, rd_box);
      kept_q   <= kept_merged;
    end
    // results trail by one kept box so the final one can carry the last flag
    if (cmd_i.commit || cmd_i.flush) begin
      res_q <= '{out_x: pend_q.x, out_y: pend_q.y, out_width: pend_q.w,
                 out_height: pend_q.h, out_last: cmd_i.flush, out_dropped: ovf_q};
    end
    if (cmd_i.commit) begin
      pend_q <= box_to_rect(kept_q);
    end
  end

  assign count_o        = count_q;
  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

endmodule

>>> hdl/grm_ctrl.sv
// controller: load, outer scan and inner absorb sequencing of the merge
// depends on grm_pkg and greedy_rectangle_merge_core_assert.svh
`include "greedy_rectangle_merge_core_assert.svh"
module grm_ctrl import grm_pkg::*; #(
  parameter int MAX_RECTS = 64,
  localparam int AW = $clog2(MAX_RECTS),
  localparam int CW = $clog2(MAX_RECTS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          last_i,
  input  logic [CW-1:0] count_i,
  input  logic          absorbed_i,
  output logic          busy_o,
  output grm_cmd_t      cmd_o,
  output logic [AW-1:0] rd_addr_o,
  output logic [AW-1:0] flag_idx_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_INNER,
    ST_FIN
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic          busy_q;
  logic [CW-1:0] nxt_i;
  logic [CW-1:0] nxt_j;

  assign nxt_i = i_q + 1'b1;
  assign nxt_j = j_q + 1'b1;

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    cmd_o      = '0;
    rd_addr_o  = i_q[AW-1:0];
    flag_idx_o = i_q[AW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (start_i && !busy_q) begin
          cmd_o.store = 1'b1;
          if (last_i) begin
            state_d = ST_SCAN;
            i_d     = '0;
          end
        end
      end
      ST_SCAN: begin
        if (i_q == count_i) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end else if (absorbed_i) begin
          i_d = nxt_i;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load_kept = 1'b1;
        i_d             = nxt_i;
        j_d             = nxt_i;
        rd_addr_o       = nxt_i[AW-1:0];
        if (nxt_i < count_i) begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_INNER;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_INNER: begin
        // data of rectangle j is on the ram output this cycle
        cmd_o.test = 1'b1;
        flag_idx_o = j_q[AW-1:0];
        rd_addr_o  = nxt_j[AW-1:0];
        if (nxt_j < count_i) begin
          cmd_o.rd_en = 1'b1;
          j_d         = nxt_j;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_SCAN;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy_o = busy_q;

  `GRM_ASSERT(a_test_after_read, clk_i, rst_ni, (cmd_o.test |-> $past(cmd_o.rd_en)))
  `GRM_ASSERT(a_load_after_read, clk_i, rst_ni, (cmd_o.load_kept |-> $past(cmd_o.rd_en)))
  `GRM_ASSERT(a_flush_frees, clk_i, rst_ni, (cmd_o.flush |=> !busy_q))
  `GRM_ASSERT(a_one_cmd, clk_i, rst_ni,
              ($onehot0({cmd_o.store, cmd_o.load_kept, cmd_o.test, cmd_o.commit, cmd_o.flush})))
  // control is known to be idle from the edge after reset is seen low
  `GRM_ASSERT_ALWAYS(a_reset_idle, clk_i, (!rst_ni |=> (!busy_q && state_q == ST_IDLE)))

endmodule

>>> hdl/greedy_rectangle_merge_core.sv
// load: one rectangle per cycle while busy is low; the item with in_last starts the merge
// merge of n stored rectangles: per kept rectangle a scan step, a load step, a test of each
// later entry and a finish step; absorbed entries are skipped in the scan; all reads use
// the single read port of the rectangle store. results trail by one kept box, one per cycle
// strobe, and the receiver cannot stall. reset (async, low) clears control, margin back to 10
module greedy_rectangle_merge_core import grm_pkg::*; #(
  parameter int MAX_RECTS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  rect_in_t               in_item_i,
  output logic                   result_valid_o,
  output rect_out_t              result_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [MARGIN_BITS-1:0] cfg_data_i
);

  localparam int AW = $clog2(MAX_RECTS);
  localparam int CW = $clog2(MAX_RECTS + 1);

  grm_cmd_t      cmd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] flag_idx;
  logic [CW-1:0] count;
  logic          absorbed;

  assign cfg_ready_o = !busy;

  grm_ctrl #(
    .MAX_RECTS(MAX_RECTS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .last_i    (in_item_i.in_last),
    .count_i   (count),
    .absorbed_i(absorbed),
    .busy_o    (busy),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr),
    .flag_idx_o(flag_idx)
  );

  grm_datapath #(
    .MAX_RECTS(MAX_RECTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .rd_addr_i     (rd_addr),
    .flag_idx_i    (flag_idx),
    .item_i        (in_item_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .count_o       (count),
    .absorbed_o    (absorbed),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

>>> verif/greedy_rectangle_merge_core_tb.sv
// self-checking testbench for greedy_rectangle_merge_core: directed table, then random lists
// of rectangles checked against an in-bench merge predictor; depends on grm_pkg and the core
module greedy_rectangle_merge_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import grm_pkg::*;

  localparam int LIST_DEPTH    = 64;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEM_TARGET   = 480;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int DIR_ROWS      = 21;
  localparam int POS_SPAN      = 1 << COORD_BITS;

  typedef struct {
    int x;
    int y;
    int w;
    int h;
  } area_t;

  typedef struct packed {
    rect_in_t  item;
    logic      typed;
    rect_out_t want;
  } dir_row_t;

  localparam rect_out_t NO_WANT = '0;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  rect_in_t               in_item_i = '0;
  logic                   result_valid_o;
  rect_out_t              result_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [MARGIN_BITS-1:0] cfg_data_i = '0;

  area_t                  pending_rects [$];
  bit                     list_overflow = 1'b0;
  logic [MARGIN_BITS-1:0] margin_model = MARGIN_RESET;
  rect_out_t              merged_q [$];
  int                     mismatches = 0;
  int                     items_sent = 0;
  int                     cycle_count = 0;

  // typed-in rows are single-rectangle lists, the box comes back unchanged
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{12'd0, 12'd0, 13'd1, 13'd1, 1'b1}, 1'b1,
      '{12'd0, 12'd0, 13'd1, 13'd1, 1'b1, 1'b0}},
    '{'{12'd4095, 12'd4095, 13'd4096, 13'd4096, 1'b1}, 1'b1,
      '{12'd4095, 12'd4095, 13'd4096, 13'd4096, 1'b1, 1'b0}},
    '{'{12'd4095, 12'd0, 13'd8191, 13'd8191, 1'b1}, 1'b1,
      '{12'd4095, 12'd0, 13'd8191, 13'd8191, 1'b1, 1'b0}},
    '{'{12'd100, 12'd100, 13'd0, 13'd50, 1'b1}, 1'b1,
      '{12'd100, 12'd100, 13'd0, 13'd50, 1'b1, 1'b0}},
    // plain overlap
    '{'{12'd10, 12'd10, 13'd20, 13'd20, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd25, 12'd15, 13'd20, 13'd20, 1'b1}, 1'b0, NO_WANT},
    // gap bridged by the margin
    '{'{12'd100, 12'd100, 13'd10, 13'd10, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd115, 12'd100, 13'd10, 13'd10, 1'b1}, 1'b0, NO_WANT},
    // gap too wide, two kept boxes
    '{'{12'd100, 12'd100, 13'd10, 13'd10, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd200, 12'd100, 13'd10, 13'd10, 1'b1}, 1'b0, NO_WANT},
    // zero-width kept box gets replaced by what it absorbs
    '{'{12'd50, 12'd50, 13'd0, 13'd10, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd45, 12'd50, 13'd20, 13'd10, 1'b1}, 1'b0, NO_WANT},
    // zero-height box never absorbs or gets absorbed
    '{'{12'd300, 12'd300, 13'd10, 13'd0, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd300, 12'd300, 13'd10, 13'd10, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd305, 12'd305, 13'd10, 13'd10, 1'b1}, 1'b0, NO_WANT},
    // union past the image saturates the width
    '{'{12'd0, 12'd0, 13'd4096, 13'd10, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd4000, 12'd0, 13'd8191, 13'd10, 1'b1}, 1'b0, NO_WANT},
    // growth only reaches later entries, the skipped one stays separate
    '{'{12'd0, 12'd0, 13'd30, 13'd30, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd500, 12'd500, 13'd10, 13'd10, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd25, 12'd25, 13'd480, 13'd480, 1'b0}, 1'b0, NO_WANT},
    '{'{12'd4095, 12'd4095, 13'd1, 13'd1, 1'b1}, 1'b0, NO_WANT}
  };

  greedy_rectangle_merge_core #(
    .MAX_RECTS(LIST_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_item_i      (in_item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int imin(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int imax(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic bit area_empty(area_t a);
    return (a.w <= 0) || (a.h <= 0);
  endfunction

  function automatic bit areas_overlap(area_t a, area_t b);
    int ow;
    int oh;
    ow = imin(a.x + a.w, b.x + b.w) - imax(a.x, b.x);
    oh = imin(a.y + a.h, b.y + b.h) - imax(a.y, b.y);
    return (ow > 0) && (oh > 0);
  endfunction

  function automatic area_t area_union(area_t a, area_t b);
    area_t u;
    int    x1;
    int    y1;
    if (area_empty(a)) begin
      u = b;
    end else if (!area_empty(b)) begin
      u.x = imin(a.x, b.x);
      u.y = imin(a.y, b.y);
      x1  = imax(a.x + a.w, b.x + b.w);
      y1  = imax(a.y + a.h, b.y + b.h);
      u.w = x1 - u.x;
      u.h = y1 - u.y;
    end else begin
      u = a;
    end
    return u;
  endfunction

  function automatic logic [SIZE_BITS-1:0] clip_size(int v);
    logic [SIZE_BITS-1:0] s;
    if (v < 0) begin
      s = '0;
    end else if (v > int'(SIZE_MAX)) begin
      s = SIZE_MAX;
    end else begin
      s = SIZE_BITS'(v);
    end
    return s;
  endfunction

  // stores the item; on in_last merges the list and queues the kept boxes
  function automatic void predict_merge(rect_in_t it);
    area_t     r;
    area_t     kept;
    area_t     search;
    area_t     cand;
    bit        absorbed [LIST_DEPTH];
    rect_out_t boxes [$];
    rect_out_t res;
    int        n;
    r.x = int'(it.in_x);
    r.y = int'(it.in_y);
    r.w = int'(it.in_width);
    r.h = int'(it.in_height);
    if (pending_rects.size() < LIST_DEPTH) begin
      pending_rects.insert(pending_rects.size(), r);
    end else begin
      list_overflow = 1'b1;
    end
    if (!it.in_last) return;
    n = pending_rects.size();
    foreach (absorbed[k]) absorbed[k] = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!absorbed[i]) begin
        kept     = pending_rects[i];
        search   = kept;
        search.x = search.x - int'(margin_model);
        search.w = search.w + 2 * int'(margin_model);
        for (int j = i + 1; j < n; j++) begin
          cand = pending_rects[j];
          if (!absorbed[j] && areas_overlap(cand, search)) begin
            search      = area_union(search, cand);
            kept        = area_union(kept, cand);
            absorbed[j] = 1'b1;
          end
        end
        res.out_x       = COORD_BITS'(imax(kept.x, 0));
        res.out_y       = COORD_BITS'(imax(kept.y, 0));
        res.out_width   = clip_size(kept.w);
        res.out_height  = clip_size(kept.h);
        res.out_last    = 1'b0;
        res.out_dropped = list_overflow;
        boxes.insert(boxes.size(), res);
      end
    end
    if (boxes.size() > 0) boxes[boxes.size() - 1].out_last = 1'b1;
    foreach (boxes[k]) merged_q.insert(merged_q.size(), boxes[k]);
    pending_rects.delete();
    list_overflow = 1'b0;
  endfunction

  function automatic void check_merged(rect_out_t got);
    rect_out_t want;
    bit        bad;
    if (merged_q.size() == 0) begin
      if (mismatches < 10) begin
        $display("unexpected merged box x=%0d y=%0d w=%0d h=%0d last=%0b drop=%0b",
                 got.out_x, got.out_y, got.out_width, got.out_height,
                 got.out_last, got.out_dropped);
      end
      mismatches++;
    end else begin
      want = merged_q.pop_front();
      bad  = (got.out_x !== want.out_x) || (got.out_y !== want.out_y) ||
             (got.out_width !== want.out_width) || (got.out_height !== want.out_height) ||
             (got.out_last !== want.out_last) || (got.out_dropped !== want.out_dropped);
      if (bad) begin
        if (mismatches < 10) begin
          $display("merged box mismatch: exp x=%0d y=%0d w=%0d h=%0d last=%0b drop=%0b",
                   want.out_x, want.out_y, want.out_width, want.out_height,
                   want.out_last, want.out_dropped);
          $display("                     got x=%0d y=%0d w=%0d h=%0d last=%0b drop=%0b",
                   got.out_x, got.out_y, got.out_width, got.out_height,
                   got.out_last, got.out_dropped);
        end
        mismatches++;
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) check_merged(result_o);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_rect(rect_in_t it, bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_merge(it);
    items_sent++;
  endtask

  // hold the sender until every merged box is back and the core has settled
  task automatic wait_idle();
    start <= 1'b0;
    while (merged_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_margin(logic [MARGIN_BITS-1:0] m);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i  <= 1'b0;
    margin_model = m;
  endtask

  function automatic rect_in_t random_rect(int cx, int cy);
    rect_in_t it;
    int       pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      it.in_x      = COORD_BITS'($urandom_range(0, POS_SPAN - 1));
      it.in_y      = COORD_BITS'($urandom_range(0, POS_SPAN - 1));
      it.in_width  = SIZE_BITS'($urandom_range(0, int'(SIZE_MAX)));
      it.in_height = SIZE_BITS'($urandom_range(0, int'(SIZE_MAX)));
    end else begin
      // clustered around the list center so merges happen
      it.in_x      = COORD_BITS'((cx + $urandom_range(0, 150)) % POS_SPAN);
      it.in_y      = COORD_BITS'((cy + $urandom_range(0, 150)) % POS_SPAN);
      it.in_width  = (pick == 3) ? '0 : SIZE_BITS'($urandom_range(1, 40));
      it.in_height = (pick == 4) ? '0 : SIZE_BITS'($urandom_range(1, 40));
    end
    it.in_last = 1'b0;
    return it;
  endfunction

  task automatic run_list(int len);
    rect_in_t it;
    int       cx;
    int       cy;
    bit       quiet;
    quiet = ($urandom_range(0, 3) == 0);
    cx    = $urandom_range(0, POS_SPAN - 1);
    cy    = $urandom_range(0, POS_SPAN - 1);
    for (int k = 0; k < len; k++) begin
      it         = random_rect(cx, cy);
      it.in_last = (k == len - 1);
      send_rect(it, quiet);
    end
  endtask

  initial begin
    int                     phase;
    int                     len;
    logic [MARGIN_BITS-1:0] m;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      send_rect(dir_rows[r].item, 1'b0);
      if (dir_rows[r].typed) begin
        // typed-in value replaces the predicted one
        void'(merged_q.pop_back());
        merged_q.insert(merged_q.size(), dir_rows[r].want);
      end
    end
    wait_idle();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: m = '0;
        1: m = '1;
        2: m = MARGIN_RESET;
        default: m = MARGIN_BITS'($urandom_range(0, 255));
      endcase
      write_margin(m);
      // full list with overflow, then exactly full
      if (phase == 1 || phase == 5) run_list(LIST_DEPTH + $urandom_range(1, 3));
      if (phase == 3) run_list(LIST_DEPTH);
      repeat (5) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        run_list(len);
      end
      wait_idle();
      phase++;
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
